/* hdl/lisc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lisc_pkg
// Shared types, codes and helpers for the link interval switch controller.
// ----------------------------------------------------------------------------
package lisc_pkg;

    // Default counter width of the change and fast-hold timers
    localparam int TIMER_WIDTH_DEF = 16;

    // Field widths
    localparam int MODE_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int TOUT_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int RPT_W    = 4;
    localparam int LSTATE_W = 2;

    // Input mode codes
    localparam logic [MODE_W-1:0] MODE_TICK       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REQ_FAST   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REQ_SLOW   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RESPONSE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HOLD_START = 3'd4;
    localparam logic [MODE_W-1:0] MODE_HOLD_STOP  = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROUTE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ICMD      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_CONN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_DISC = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_CONN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_DISC = 3'd7;

    // Configuration reset values
    localparam logic [TOUT_W-1:0] TIMEOUT_RST   = 16'd60;
    localparam logic [BYTE_W-1:0] FAST_CONN_RST = 8'd1;
    localparam logic [BYTE_W-1:0] FAST_DISC_RST = 8'd2;
    localparam logic [BYTE_W-1:0] SLOW_CONN_RST = 8'd3;
    localparam logic [BYTE_W-1:0] SLOW_DISC_RST = 8'd4;

    // Response status byte that means accepted
    localparam logic [BYTE_W-1:0] STATUS_ACCEPT = 8'd1;

    // Link state, one-hot
    typedef enum logic [3:0] {
        ST_SLOW = 4'b0001,
        ST_S2F  = 4'b0010,
        ST_FAST = 4'b0100,
        ST_F2S  = 4'b1000
    } t_state;

    // Encoded link state on the result port
    localparam logic [LSTATE_W-1:0] LS_SLOW = 2'd0;
    localparam logic [LSTATE_W-1:0] LS_S2F  = 2'd1;
    localparam logic [LSTATE_W-1:0] LS_FAST = 2'd2;
    localparam logic [LSTATE_W-1:0] LS_F2S  = 2'd3;

    // Report codes
    typedef enum logic [RPT_W-1:0] {
        RPT_NONE      = 4'd0,
        RPT_FAST_OK   = 4'd1,
        RPT_FAST_FAIL = 4'd2,
        RPT_FAST_TOUT = 4'd3,
        RPT_SLOW_OK   = 4'd4,
        RPT_SLOW_FAIL = 4'd5,
        RPT_SLOW_TOUT = 4'd6,
        RPT_IN_FAST   = 4'd7,
        RPT_IN_SLOW   = 4'd8,
        RPT_ERR_FAST  = 4'd9,
        RPT_ERR_SLOW  = 4'd10,
        RPT_NOT_US    = 4'd11
    } t_report;

    // Classified event handed from front to back
    typedef enum logic [3:0] {
        EV_NONE       = 4'd0,
        EV_TICK       = 4'd1,
        EV_REQ_FAST   = 4'd2,
        EV_REQ_SLOW   = 4'd3,
        EV_RESP_FAST  = 4'd4,
        EV_RESP_SLOW  = 4'd5,
        EV_NOT_US     = 4'd6,
        EV_HOLD_START = 4'd7,
        EV_HOLD_STOP  = 4'd8
    } t_event;

    typedef struct packed {
        t_event ev;
        logic   ok;     // response status was accept
        logic   way;    // requested switching way
    } t_cmd;

    typedef struct packed {
        logic [TOUT_W-1:0] timeout;
        logic [BYTE_W-1:0] route;
        logic [BYTE_W-1:0] group;
        logic [BYTE_W-1:0] icmd;
        logic [BYTE_W-1:0] fast_conn;
        logic [BYTE_W-1:0] fast_disc;
        logic [BYTE_W-1:0] slow_conn;
        logic [BYTE_W-1:0] slow_disc;
    } t_cfg;

    // Queue status toward the front
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    localparam int QDEPTH = 2;

    function automatic logic [LSTATE_W-1:0] state_code(input t_state s);
        logic [LSTATE_W-1:0] c;
        unique case (s)
            ST_SLOW: c = LS_SLOW;
            ST_S2F:  c = LS_S2F;
            ST_FAST: c = LS_FAST;
            ST_F2S:  c = LS_F2S;
            default: c = LS_SLOW;
        endcase
        return c;
    endfunction

endpackage

/* hdl/link_interval_switch_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_interval_switch_controller
// Negotiates a slow or fast connection interval with a peer; one result per
// event.
// ----------------------------------------------------------------------------
// Every accepted event (tick, fast or slow request, peer response, hold start
// or stop) gives exactly one result transfer carrying the command to send,
// a report code and the link state after the event. Events are classified on
// entry and pass through a two-entry queue to the executor, which updates
// the state machine and both timers when it executes an event and registers the
// result; one event per cycle is sustained while the output is taken, and an
// event's result is offered after the queue entry and the result register.
// Configuration writes are registered and must be made while no event is
// in flight.
// ----------------------------------------------------------------------------
module link_interval_switch_controller #(
    parameter int TIMER_WIDTH = lisc_pkg::TIMER_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [lisc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lisc_pkg::CFG_DAT_W-1:0] i_cfg_data,
    // event channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [lisc_pkg::MODE_W-1:0]    i_mode,
    input  logic                           i_switch_way,
    input  logic [lisc_pkg::BYTE_W-1:0]    i_resp_route,
    input  logic [lisc_pkg::BYTE_W-1:0]    i_resp_group,
    input  logic [lisc_pkg::BYTE_W-1:0]    i_resp_command,
    input  logic [lisc_pkg::BYTE_W-1:0]    i_resp_kind,
    input  logic [lisc_pkg::BYTE_W-1:0]    i_resp_status,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_send_valid,
    output logic [lisc_pkg::BYTE_W-1:0]    o_send_code,
    output logic [lisc_pkg::RPT_W-1:0]     o_report_code,
    output logic [lisc_pkg::LSTATE_W-1:0]  o_link_state_out
);

    lisc_pkg::t_cfg   r_cfg;
    lisc_pkg::t_qstat w_qstat;
    lisc_pkg::t_cmd   w_front_cmd;
    lisc_pkg::t_cmd   w_head_cmd;
    logic             w_push;
    logic             w_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout   <= lisc_pkg::TIMEOUT_RST;
            r_cfg.route     <= '0;
            r_cfg.group     <= '0;
            r_cfg.icmd      <= '0;
            r_cfg.fast_conn <= lisc_pkg::FAST_CONN_RST;
            r_cfg.fast_disc <= lisc_pkg::FAST_DISC_RST;
            r_cfg.slow_conn <= lisc_pkg::SLOW_CONN_RST;
            r_cfg.slow_disc <= lisc_pkg::SLOW_DISC_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lisc_pkg::REG_TIMEOUT:   r_cfg.timeout   <= i_cfg_data;
                lisc_pkg::REG_ROUTE:     r_cfg.route     <= i_cfg_data[lisc_pkg::BYTE_W-1:0];
                lisc_pkg::REG_GROUP:     r_cfg.group     <= i_cfg_data[lisc_pkg::BYTE_W-1:0];
                lisc_pkg::REG_ICMD:      r_cfg.icmd      <= i_cfg_data[lisc_pkg::BYTE_W-1:0];
                lisc_pkg::REG_FAST_CONN: r_cfg.fast_conn <= i_cfg_data[lisc_pkg::BYTE_W-1:0];
                lisc_pkg::REG_FAST_DISC: r_cfg.fast_disc <= i_cfg_data[lisc_pkg::BYTE_W-1:0];
                lisc_pkg::REG_SLOW_CONN: r_cfg.slow_conn <= i_cfg_data[lisc_pkg::BYTE_W-1:0];
                lisc_pkg::REG_SLOW_DISC: r_cfg.slow_disc <= i_cfg_data[lisc_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    lisc_front u_front (
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_mode         (i_mode),
        .i_switch_way   (i_switch_way),
        .i_resp_route   (i_resp_route),
        .i_resp_group   (i_resp_group),
        .i_resp_command (i_resp_command),
        .i_resp_kind    (i_resp_kind),
        .i_resp_status  (i_resp_status),
        .i_cfg          (r_cfg),
        .i_qstat        (w_qstat),
        .o_push         (w_push),
        .o_cmd          (w_front_cmd)
    );

    lisc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_stat  (w_qstat)
    );

    lisc_back #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_qstat          (w_qstat),
        .i_cmd            (w_head_cmd),
        .o_pop            (w_pop),
        .o_valid          (o_out_valid),
        .i_ready          (i_out_ready),
        .o_send_valid     (o_send_valid),
        .o_send_code      (o_send_code),
        .o_report_code    (o_report_code),
        .o_link_state_out (o_link_state_out)
    );

    // A result without a command carries a zero command byte
    a_no_send_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_send_valid |-> o_send_code == '0)
        else $error("command byte set without a command");

    // Foreign responses never cause a command
    a_not_us_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_report_code == lisc_pkg::RPT_NOT_US |-> !o_send_valid)
        else $error("command sent on a foreign response");

    // Fast ok always leaves the link fast
    a_fast_ok_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_report_code == lisc_pkg::RPT_FAST_OK
        |-> o_link_state_out == lisc_pkg::LS_FAST)
        else $error("fast ok reported outside fast state");

    // Slow ok always leaves the link slow
    a_slow_ok_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_report_code == lisc_pkg::RPT_SLOW_OK
        |-> o_link_state_out == lisc_pkg::LS_SLOW)
        else $error("slow ok reported outside slow state");

endmodule

/* hdl/lisc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lisc_front
// Input side: takes event transfers and classifies them into commands.
// ----------------------------------------------------------------------------
module lisc_front (
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [lisc_pkg::MODE_W-1:0] i_mode,
    input  logic                        i_switch_way,
    input  logic [lisc_pkg::BYTE_W-1:0] i_resp_route,
    input  logic [lisc_pkg::BYTE_W-1:0] i_resp_group,
    input  logic [lisc_pkg::BYTE_W-1:0] i_resp_command,
    input  logic [lisc_pkg::BYTE_W-1:0] i_resp_kind,
    input  logic [lisc_pkg::BYTE_W-1:0] i_resp_status,
    input  lisc_pkg::t_cfg              i_cfg,
    input  lisc_pkg::t_qstat            i_qstat,
    output logic                        o_push,
    output lisc_pkg::t_cmd              o_cmd
);

    logic w_addr_ok;
    logic w_kind_fast;
    logic w_kind_slow;

    assign o_ready = !i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full;

    // Response address and kind matching
    assign w_addr_ok   = (i_resp_route == i_cfg.route) && (i_resp_command == i_cfg.icmd)
                      && (i_resp_group == i_cfg.group);
    assign w_kind_fast = (i_resp_kind == i_cfg.fast_conn) || (i_resp_kind == i_cfg.fast_disc);
    assign w_kind_slow = (i_resp_kind == i_cfg.slow_conn) || (i_resp_kind == i_cfg.slow_disc);

    // Mode decode; fast kind wins over slow when codes overlap
    always_comb begin
        o_cmd.ok  = (i_resp_status == lisc_pkg::STATUS_ACCEPT);
        o_cmd.way = i_switch_way;
        unique case (i_mode)
            lisc_pkg::MODE_TICK:       o_cmd.ev = lisc_pkg::EV_TICK;
            lisc_pkg::MODE_REQ_FAST:   o_cmd.ev = lisc_pkg::EV_REQ_FAST;
            lisc_pkg::MODE_REQ_SLOW:   o_cmd.ev = lisc_pkg::EV_REQ_SLOW;
            lisc_pkg::MODE_RESPONSE: begin
                if (!w_addr_ok)       o_cmd.ev = lisc_pkg::EV_NOT_US;
                else if (w_kind_fast) o_cmd.ev = lisc_pkg::EV_RESP_FAST;
                else if (w_kind_slow) o_cmd.ev = lisc_pkg::EV_RESP_SLOW;
                else                  o_cmd.ev = lisc_pkg::EV_NOT_US;
            end
            lisc_pkg::MODE_HOLD_START: o_cmd.ev = lisc_pkg::EV_HOLD_START;
            lisc_pkg::MODE_HOLD_STOP:  o_cmd.ev = lisc_pkg::EV_HOLD_STOP;
            default:                   o_cmd.ev = lisc_pkg::EV_NONE;
        endcase
    end

endmodule

/* hdl/lisc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lisc_queue
// Two-entry command queue between the classifier and the executor.
// ----------------------------------------------------------------------------
module lisc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lisc_pkg::t_cmd   i_cmd,
    input  logic             i_pop,
    output lisc_pkg::t_cmd   o_cmd,
    output lisc_pkg::t_qstat o_stat
);

    localparam int PTR_W = $clog2(lisc_pkg::QDEPTH);
    localparam int CNT_W = $clog2(lisc_pkg::QDEPTH + 1);

    lisc_pkg::t_cmd   r_mem [lisc_pkg::QDEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;

    assign o_stat.full  = (r_cnt == CNT_W'(lisc_pkg::QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_cmd        = r_mem[r_rptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + 1'b1;
            if (i_pop)  r_rptr <= r_rptr + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

/* hdl/lisc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lisc_back
// Executor: link state machine, change and fast-hold timers, result register.
// ----------------------------------------------------------------------------
module lisc_back #(
    parameter int TIMER_WIDTH = lisc_pkg::TIMER_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lisc_pkg::t_cfg                i_cfg,
    input  lisc_pkg::t_qstat              i_qstat,
    input  lisc_pkg::t_cmd                i_cmd,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_send_valid,
    output logic [lisc_pkg::BYTE_W-1:0]   o_send_code,
    output logic [lisc_pkg::RPT_W-1:0]    o_report_code,
    output logic [lisc_pkg::LSTATE_W-1:0] o_link_state_out
);

    localparam logic [31:0] MASK32 = 32'((64'd1 << TIMER_WIDTH) - 64'd1);

    lisc_pkg::t_state       r_state, n_state;
    logic                   r_way, n_way;
    logic [TIMER_WIDTH-1:0] r_ccnt, n_ccnt;
    logic                   r_crun, n_crun;
    logic [TIMER_WIDTH-1:0] r_hcnt, n_hcnt;
    logic                   r_hrun, n_hrun;

    logic                   r_out_valid;
    logic                   r_send_valid, n_send_valid;
    logic [lisc_pkg::BYTE_W-1:0]   r_send_code, n_send_code;
    lisc_pkg::t_report      r_report, n_report;
    logic [lisc_pkg::LSTATE_W-1:0] r_lstate;

    logic [31:0]            w_to32;
    logic [TIMER_WIDTH-1:0] w_limit;
    logic [TIMER_WIDTH:0]   w_cnext;
    logic [TIMER_WIDTH:0]   w_hnext;
    logic                   w_cexp;
    logic                   w_hexp;

    // Timer limit, clamped to the counter range
    assign w_to32  = 32'(i_cfg.timeout);
    assign w_limit = (w_to32 > MASK32) ? TIMER_WIDTH'(MASK32) : TIMER_WIDTH'(w_to32);

    // Per-tick increments and expiry
    assign w_cnext = {1'b0, r_ccnt} + 1'b1;
    assign w_hnext = {1'b0, r_hcnt} + 1'b1;
    assign w_cexp  = r_crun && (w_cnext >= {1'b0, w_limit});
    assign w_hexp  = r_hrun && (w_hnext >= {1'b0, w_limit});

    // Execute the head command when the result register can take a result
    assign o_pop = !i_qstat.empty && (!r_out_valid || i_ready);

    // Next state and result
    always_comb begin
        n_state      = r_state;
        n_way        = r_way;
        n_ccnt       = r_ccnt;
        n_crun       = r_crun;
        n_hcnt       = r_hcnt;
        n_hrun       = r_hrun;
        n_send_valid = 1'b0;
        n_send_code  = '0;
        n_report     = lisc_pkg::RPT_NONE;

        unique case (i_cmd.ev)
            lisc_pkg::EV_TICK: begin
                // change timer first
                if (r_crun) begin
                    if (w_cexp) begin
                        n_crun = 1'b0;
                        n_ccnt = '0;
                        if (r_state == lisc_pkg::ST_S2F) begin
                            n_report = lisc_pkg::RPT_FAST_TOUT;
                        end else if (r_state == lisc_pkg::ST_F2S) begin
                            n_crun       = 1'b1;
                            n_send_valid = 1'b1;
                            n_send_code  = i_cfg.slow_disc;
                            n_report     = lisc_pkg::RPT_SLOW_TOUT;
                        end
                    end else begin
                        n_ccnt = w_cnext[TIMER_WIDTH-1:0];
                    end
                end
                // then the fast-hold timer
                if (r_hrun) begin
                    if (w_hexp) begin
                        n_hrun = 1'b0;
                        n_hcnt = '0;
                        if (r_state == lisc_pkg::ST_FAST) begin
                            n_send_valid = 1'b1;
                            n_send_code  = r_way ? i_cfg.slow_disc : i_cfg.slow_conn;
                            n_state      = lisc_pkg::ST_F2S;
                            n_crun       = 1'b1;
                            n_ccnt       = '0;
                        end
                    end else begin
                        n_hcnt = w_hnext[TIMER_WIDTH-1:0];
                    end
                end
            end
            lisc_pkg::EV_REQ_FAST: begin
                n_crun       = 1'b1;
                n_ccnt       = '0;
                n_state      = lisc_pkg::ST_S2F;
                n_send_valid = 1'b1;
                n_send_code  = i_cmd.way ? i_cfg.fast_disc : i_cfg.fast_conn;
                n_way        = i_cmd.way;
            end
            lisc_pkg::EV_REQ_SLOW: begin
                n_crun       = 1'b1;
                n_ccnt       = '0;
                n_state      = lisc_pkg::ST_F2S;
                n_send_valid = 1'b1;
                n_send_code  = r_way ? i_cfg.slow_disc : i_cfg.slow_conn;
            end
            lisc_pkg::EV_RESP_FAST: begin
                if (r_state == lisc_pkg::ST_F2S) begin
                    n_report = lisc_pkg::RPT_IN_SLOW;
                end else if (r_state == lisc_pkg::ST_S2F) begin
                    n_crun   = 1'b0;
                    n_ccnt   = '0;
                    n_state  = i_cmd.ok ? lisc_pkg::ST_FAST : lisc_pkg::ST_SLOW;
                    n_report = i_cmd.ok ? lisc_pkg::RPT_FAST_OK : lisc_pkg::RPT_FAST_FAIL;
                end else if (i_cmd.ok && r_state == lisc_pkg::ST_FAST) begin
                    n_report = lisc_pkg::RPT_FAST_OK;
                end else begin
                    // accepted while slow, or refused while slow or fast
                    n_state      = lisc_pkg::ST_F2S;
                    n_crun       = 1'b1;
                    n_ccnt       = '0;
                    n_send_valid = 1'b1;
                    n_send_code  = i_cfg.slow_disc;
                    n_report     = i_cmd.ok ? lisc_pkg::RPT_ERR_FAST : lisc_pkg::RPT_ERR_SLOW;
                end
            end
            lisc_pkg::EV_RESP_SLOW: begin
                if (r_state == lisc_pkg::ST_S2F) begin
                    n_report = lisc_pkg::RPT_IN_FAST;
                end else if (i_cmd.ok) begin
                    if (r_state == lisc_pkg::ST_FAST) begin
                        n_report = lisc_pkg::RPT_ERR_SLOW;
                    end else begin
                        if (r_state == lisc_pkg::ST_F2S) begin
                            n_crun = 1'b0;
                            n_ccnt = '0;
                        end
                        n_state  = lisc_pkg::ST_SLOW;
                        n_report = lisc_pkg::RPT_SLOW_OK;
                    end
                end else begin
                    // refused: re-send via disconnect, state unchanged
                    n_crun       = 1'b1;
                    n_ccnt       = '0;
                    n_send_valid = 1'b1;
                    n_send_code  = i_cfg.slow_disc;
                    n_report     = (r_state == lisc_pkg::ST_FAST) ? lisc_pkg::RPT_ERR_SLOW
                                                                  : lisc_pkg::RPT_SLOW_FAIL;
                end
            end
            lisc_pkg::EV_NOT_US: n_report = lisc_pkg::RPT_NOT_US;
            lisc_pkg::EV_HOLD_START: begin
                n_hcnt = '0;
                n_hrun = 1'b1;
            end
            lisc_pkg::EV_HOLD_STOP: begin
                n_hcnt = '0;
                n_hrun = 1'b0;
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lisc_pkg::ST_SLOW;
            r_way       <= 1'b0;
            r_ccnt      <= '0;
            r_crun      <= 1'b0;
            r_hcnt      <= '0;
            r_hrun      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_state <= n_state;
                r_way   <= n_way;
                r_ccnt  <= n_ccnt;
                r_crun  <= n_crun;
                r_hcnt  <= n_hcnt;
                r_hrun  <= n_hrun;
            end
            if (o_pop)        r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_send_valid <= n_send_valid;
            r_send_code  <= n_send_code;
            r_report     <= n_report;
            r_lstate     <= lisc_pkg::state_code(n_state);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_send_valid     = r_send_valid;
    assign o_send_code      = r_send_code;
    assign o_report_code    = r_report;
    assign o_link_state_out = r_lstate;

endmodule
